// ----- rtl/sample_table_linear_interpolator_top_macros.svh -----
// Assertion macros shared by the interpolator RTL.
`ifndef SAMPLE_TABLE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define SAMPLE_TABLE_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define STLI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("interpolator check failed");
`define STLI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("interpolator check failed");
`else
`define STLI_ASSERT_IMP(label, ante, cons)
`define STLI_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/stli_pkg.sv -----
// Types and constants of the sample table interpolator.
`timescale 1ns / 1ps
package stli_pkg;
   localparam int unsigned DEF_TABLE_DEPTH = 16384;

   localparam logic       CMD_WRITE = 1'b0;
   localparam logic       CMD_QUERY = 1'b1;

   localparam logic [2:0] OUT_BELOW  = 3'd0;
   localparam logic [2:0] OUT_INTERP = 3'd1;
   localparam logic [2:0] OUT_ZERO   = 3'd2;
   localparam logic [2:0] OUT_ABOVE  = 3'd3;
   localparam logic [2:0] OUT_NONE   = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [13:0] entry_index;
      logic [31:0] sample_time;
      logic [16:0] sample_value;
      logic [31:0] query_time;
   } req_type;

   typedef struct packed {
      logic [16:0] value;
      logic [2:0]  outcome;
      logic [13:0] segment;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIRST, ST_LAST, ST_LOAD, ST_SCAN,
      ST_DIV, ST_MUL, ST_BLEND, ST_EMIT
   } state_type;
endpackage

// ----- rtl/sample_table_linear_interpolator_top.sv -----
// Sample table linear interpolator: table memory, scan sequencer and serial divider.
// Write word: accepted while idle, no result.
// Query word: a time at or below the first time, or at or past the last, returns that entry;
// else segments are scanned (ST_LOAD, ST_SCAN) and the result goes out from ST_EMIT, after
// ST_DIV, ST_MUL and ST_BLEND when interpolated. The next word waits for the result; a stalled result holds it.
// Reset clears control state and sets used_ff to 1; the table is undefined.
`timescale 1ns / 1ps
`include "sample_table_linear_interpolator_top_macros.svh"
module sample_table_linear_interpolator_top
   import stli_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata
);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [31:0] mem_t [TABLE_DEPTH];
   logic [16:0] mem_x [TABLE_DEPTH];
   logic [31:0] rd_t_ff;
   logic [16:0] rd_x_ff;
   logic [AW-1:0] rd_addr;

   state_type   state_ff, state_in;
   logic [14:0] used_ff;
   logic [31:0] q_ff, q_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0] prev_t_ff, prev_t_in;
   logic [16:0] prev_x_ff, prev_x_in;
   logic [16:0] x1_ff, x1_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dt_ff, dt_in;
   logic [16:0] w_ff, w_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [33:0] prod0_ff, prod1_ff;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_take, out_free, in_range, hit, ge;
   logic [31:0] n32, idx_w32, last32, cur32, seg32;
   logic [AW-1:0] last, wr_addr;
   logic [16:0] w_inv;
   logic [34:0] blend_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the used count to 1..TABLE_DEPTH
   always_comb begin
      n32 = 32'(used_ff);
      if (n32 == 32'd0) n32 = 32'd1;
      if (n32 > 32'(TABLE_DEPTH)) n32 = 32'(TABLE_DEPTH);
      last32 = n32 - 32'd1;
      last = last32[AW-1:0];
   end

   assign idx_w32  = 32'(req_data.entry_index);
   assign in_range = idx_w32 < 32'(TABLE_DEPTH);
   assign wr_addr  = idx_w32[AW-1:0];
   assign hit      = (prev_t_ff <= q_ff) && (q_ff <= rd_t_ff);
   assign ge       = rem_ff >= {1'b0, dt_ff};
   assign w_inv    = 17'(18'd65536 - {1'b0, w_ff});
   assign blend_sum = {1'b0, prod0_ff} + {1'b0, prod1_ff};
   assign cur32    = 32'(idx_ff);
   assign seg32    = 32'(idx_ff);

   always_ff @(posedge clock) begin
      if (req_take && req_data.cmd == CMD_WRITE && in_range) begin
         mem_t[wr_addr] <= req_data.sample_time;
         mem_x[wr_addr] <= req_data.sample_value;
      end
      rd_t_ff <= mem_t[rd_addr];
      rd_x_ff <= mem_x[rd_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take && req_data.cmd == CMD_QUERY) state_in = ST_FIRST;
         ST_FIRST: state_in = (q_ff <= rd_t_ff) ? ST_EMIT : ST_LAST;
         ST_LAST:  state_in = (q_ff >= rd_t_ff) ? ST_EMIT : ST_LOAD;
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN: begin
            priority if (hit) state_in = (rd_t_ff == prev_t_ff) ? ST_EMIT : ST_DIV;
            else if (idx_ff + AW'(1) == last) state_in = ST_EMIT;
            else state_in = ST_SCAN;
         end
         ST_DIV:   if (cnt_ff == 5'd16) state_in = ST_MUL;
         ST_MUL:   state_in = ST_BLEND;
         ST_BLEND: state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and read address
   always_comb begin
      rd_addr   = '0;
      q_in      = q_ff;
      idx_in    = idx_ff;
      prev_t_in = prev_t_ff;
      prev_x_in = prev_x_ff;
      x1_in     = x1_ff;
      rem_in    = rem_ff;
      dt_in     = dt_ff;
      w_in      = w_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_in = req_data.query_time;
         end
         ST_FIRST: begin
            rd_addr = last;
            res_in  = '{value: rd_x_ff, outcome: OUT_BELOW, segment: '0};
         end
         ST_LAST: begin
            idx_in = '0;
            res_in = '{value: rd_x_ff, outcome: OUT_ABOVE, segment: last32[13:0]};
         end
         ST_LOAD: begin
            rd_addr   = idx_ff + AW'(1);
            prev_t_in = rd_t_ff;
            prev_x_in = rd_x_ff;
         end
         ST_SCAN: begin
            priority if (hit) begin
               res_in = '{value: prev_x_ff, outcome: OUT_ZERO, segment: seg32[13:0]};
               dt_in  = rd_t_ff - prev_t_ff;
               rem_in = {1'b0, q_ff - prev_t_ff};
               x1_in  = rd_x_ff;
               w_in   = '0;
               cnt_in = '0;
            end else begin
               // Advance one entry; the read one past last on the final step is dropped
               rd_addr   = idx_ff + AW'(2);
               idx_in    = idx_ff + AW'(1);
               prev_t_in = rd_t_ff;
               prev_x_in = rd_x_ff;
               res_in = '{value: rd_x_ff, outcome: OUT_NONE, segment: last32[13:0]};
            end
         end
         ST_DIV: begin
            w_in   = {w_ff[15:0], ge};
            rem_in = ge ? ((rem_ff - {1'b0, dt_ff}) << 1) : (rem_ff << 1);
            cnt_in = cnt_ff + 5'd1;
         end
         ST_BLEND: begin
            res_in = '{value: blend_sum[32:16], outcome: OUT_INTERP,
                       segment: seg32[13:0]};
         end
         default: ;
      endcase
      if (cur32 == 32'hFFFF_FFFF) idx_in = idx_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= 15'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) used_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      idx_ff    <= idx_in;
      prev_t_ff <= prev_t_in;
      prev_x_ff <= prev_x_in;
      x1_ff     <= x1_in;
      rem_ff    <= rem_in;
      dt_ff     <= dt_in;
      w_ff      <= w_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
      rsp_data_ff <= rsp_data_in;
      prod0_ff  <= w_inv * prev_x_ff;
      prod1_ff  <= w_ff * x1_ff;
   end

   `STLI_ASSERT_IMP(a_below_seg0, rsp_valid && rsp_data.outcome == OUT_BELOW, rsp_data.segment == '0)
   `STLI_ASSERT_NXT(a_div_exit, state_ff == ST_DIV, state_ff == ST_DIV || state_ff == ST_MUL)
   `STLI_ASSERT_IMP(a_rose_emit, $rose(rsp_valid_ff), $past(state_ff == ST_EMIT))
   `STLI_ASSERT_IMP(a_busy_stall, state_ff != ST_IDLE, req_stall)
endmodule
